[sv/mep_pkg.sv]
`default_nettype none
package mep_pkg;

   localparam int PIXEL_W     = 13;
   localparam int DIM_W       = 14;
   localparam int GRAY_W      = 8;
   localparam int COUNT_W     = 10;
   localparam int CSR_INDEX_W = 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 1'd1;

   localparam logic [DIM_W-1:0] DIM_RESET = 14'd8192;

   // 255 squared: the gray search compares g*g*(limit-1) against this times the count.
   localparam int GRAY_SCALE = 65025;
   localparam int GRAY_SQ_W  = 16;
   localparam int GRAY_BIT_W = 3;

   typedef struct packed {
      logic                  div_start;
      logic                  div_step;
      logic                  map;
      logic                  mul;
      logic                  add;
      logic                  gray_init;
      logic                  gray_sq;
      logic                  gray_cmp;
      logic [GRAY_BIT_W-1:0] gray_bit;
      logic                  out_load;
   } mep_cmd_type;

   typedef struct packed {
      logic sq_fail;
      logic bound_fail;
      logic at_limit;
   } mep_status_type;

endpackage
`default_nettype wire

[sv/mandelbrot_escape_pixel_core.sv]
`default_nettype none
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_stall   req_pixel_x, req_pixel_y
// rsp       out        rsp_valid/rsp_stall   rsp_gray, rsp_inside_res, rsp_escape_count
// csr       in         csr_write_enable      csr_index, csr_wdata
//
// One pixel at a time. A pixel is accepted, divided in the restoring dividers,
// mapped, run for escape_count+1 to escape_count+2 iterations through the
// multipliers and update adder, then put through the gray search and output.
// Reset is synchronous; it clears control state and sets the size registers to DIM_RESET.
// A held result stalls only the final load; the next pixel is computed meanwhile.
module mandelbrot_escape_pixel_core #(
   parameter int MAX_ITER  = 512,
   parameter int FRAC_BITS = 28
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [mep_pkg::PIXEL_W-1:0]     req_pixel_x,
   input  wire logic [mep_pkg::PIXEL_W-1:0]     req_pixel_y,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic      [mep_pkg::GRAY_W-1:0]      rsp_gray,
   output logic                                 rsp_inside_res,
   output logic      [mep_pkg::COUNT_W-1:0]     rsp_escape_count,
   input  wire logic                            csr_write_enable,
   input  wire logic [mep_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [mep_pkg::DIM_W-1:0]       csr_wdata
);
   import mep_pkg::*;

   logic [DIM_W-1:0] width_ff, height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_RESET;
         height_ff <= DIM_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata;
            CSR_IMAGE_HEIGHT: height_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   mep_cmd_type    cmd;
   mep_status_type status;

   mep_controller #(.FRAC_BITS(FRAC_BITS)) u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   mep_datapath #(.MAX_ITER(MAX_ITER), .FRAC_BITS(FRAC_BITS)) u_datapath (
      .clock        (clock),
      .cmd          (cmd),
      .pixel_x      (req_pixel_x),
      .pixel_y      (req_pixel_y),
      .image_width  (width_ff),
      .image_height (height_ff),
      .status       (status),
      .gray         (rsp_gray),
      .inside_res   (rsp_inside_res),
      .escape_count (rsp_escape_count)
   );

endmodule
`default_nettype wire

[sv/mep_div_lane.sv]
`default_nettype none
module mep_div_lane #(
   parameter int QW = 42
) (
   input  wire logic                        clock,
   input  wire logic                        start,
   input  wire logic                        step,
   input  wire logic [mep_pkg::PIXEL_W-1:0] pixel,
   input  wire logic [mep_pkg::DIM_W-1:0]   divisor,
   output logic      [QW-1:0]               quotient
);
   import mep_pkg::*;

   logic [QW-1:0]    num_ff, num_in;
   logic [DIM_W-1:0] rem_ff, rem_in;
   logic [DIM_W:0]   rem_sh;
   logic             ge;

   // Restoring division: the numerator shifts out at the top while quotient
   // bits shift in at the bottom, one bit per step.
   always_comb begin
      rem_sh = {rem_ff, num_ff[QW-1]};
      ge     = rem_sh >= {1'b0, divisor};
      rem_in = ge ? DIM_W'(rem_sh - {1'b0, divisor}) : rem_sh[DIM_W-1:0];
      num_in = {num_ff[QW-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= {pixel, {(QW-PIXEL_W){1'b0}}};
         rem_ff <= '0;
      end else if (step) begin
         num_ff <= num_in;
         rem_ff <= rem_in;
      end
   end

   assign quotient = num_ff;

endmodule
`default_nettype wire

[sv/mep_datapath.sv]
`default_nettype none
module mep_datapath #(
   parameter int MAX_ITER  = 512,
   parameter int FRAC_BITS = 28
) (
   input  wire logic                        clock,
   input  wire mep_pkg::mep_cmd_type        cmd,
   input  wire logic [mep_pkg::PIXEL_W-1:0] pixel_x,
   input  wire logic [mep_pkg::PIXEL_W-1:0] pixel_y,
   input  wire logic [mep_pkg::DIM_W-1:0]   image_width,
   input  wire logic [mep_pkg::DIM_W-1:0]   image_height,
   output mep_pkg::mep_status_type          status,
   output logic      [mep_pkg::GRAY_W-1:0]  gray,
   output logic                             inside_res,
   output logic      [mep_pkg::COUNT_W-1:0] escape_count
);
   import mep_pkg::*;

   localparam int W     = FRAC_BITS + 4;
   localparam int QW    = PIXEL_W + 1 + FRAC_BITS;
   localparam int CNT_W = $clog2(MAX_ITER + 1);
   localparam int LIM_W = GRAY_SQ_W + CNT_W;
   localparam int DEN   = MAX_ITER - 1;

   localparam logic [W+1:0] ONE   = (W+2)'(1) << FRAC_BITS;
   localparam logic [W+1:0] OFF_X = ONE + (ONE >> 1);
   localparam logic [W+1:0] OFF_Y = ONE;
   localparam logic [W+1:0] TOP   = (ONE << 3) - (W+2)'(1);
   localparam logic [W+1:0] BOUND = ONE << 1;
   localparam logic [W+1:0] FOUR  = ONE << 2;

   function automatic logic signed [W-1:0] map_coord(input logic [QW-1:0] q,
                                                     input logic [W+1:0]  off);
      logic signed [W+1:0] v;
      v = $signed({2'b00, q[FRAC_BITS+3:0]}) - $signed(off);
      if (q[QW-1:FRAC_BITS+4] != '0 || v > $signed(TOP)) begin
         map_coord = TOP[W-1:0];
      end else begin
         map_coord = v[W-1:0];
      end
   endfunction

   logic [DIM_W-1:0] div_x, div_y;
   logic [QW-1:0]    qx, qy;

   // A zero size is treated as one.
   assign div_x = (image_width  == '0) ? DIM_W'(1) : image_width;
   assign div_y = (image_height == '0) ? DIM_W'(1) : image_height;

   mep_div_lane #(.QW(QW)) u_div_x (
      .clock    (clock),
      .start    (cmd.div_start),
      .step     (cmd.div_step),
      .pixel    (pixel_x),
      .divisor  (div_x),
      .quotient (qx)
   );

   mep_div_lane #(.QW(QW)) u_div_y (
      .clock    (clock),
      .start    (cmd.div_start),
      .step     (cmd.div_step),
      .pixel    (pixel_y),
      .divisor  (div_y),
      .quotient (qy)
   );

   logic signed [W-1:0]   cx_ff, cy_ff, zx_ff, zy_ff;
   logic signed [W:0]     sqx_ff, sqy_ff, pxy_ff;
   logic [CNT_W-1:0]      it_ff, esc_ff;
   logic                  inside_ff;
   logic signed [2*W-1:0] mxx, myy, mxy;
   logic signed [W+1:0]   nx, ny, sum;
   logic                  stop;

   // Each product is floored to the fraction width by taking its bits above
   // the binary point; the cross term keeps one more bit for the factor two.
   assign mxx = zx_ff * zx_ff;
   assign myy = zy_ff * zy_ff;
   assign mxy = zx_ff * zy_ff;

   assign nx  = (W+2)'(sqx_ff) - (W+2)'(sqy_ff) + (W+2)'(cx_ff);
   assign ny  = (W+2)'(pxy_ff) + (W+2)'(cy_ff);
   assign sum = (W+2)'(sqx_ff) + (W+2)'(sqy_ff);

   // The squares of the current z are also the magnitude test of the step
   // that produced it, so that test runs one multiply pass later.
   assign status.sq_fail    = sum > $signed(FOUR);
   assign status.bound_fail = nx > $signed(BOUND) || nx < -$signed(BOUND) ||
                              ny > $signed(BOUND) || ny < -$signed(BOUND);
   assign status.at_limit   = it_ff == CNT_W'(MAX_ITER);
   assign stop = status.sq_fail | status.bound_fail | status.at_limit;

   always_ff @(posedge clock) begin
      if (cmd.map) begin
         cx_ff <= map_coord(qx, OFF_X);
         cy_ff <= map_coord(qy, OFF_Y);
         zx_ff <= '0;
         zy_ff <= '0;
         it_ff <= '0;
      end
      if (cmd.mul) begin
         sqx_ff <= mxx[FRAC_BITS+W:FRAC_BITS];
         sqy_ff <= myy[FRAC_BITS+W:FRAC_BITS];
         pxy_ff <= mxy[FRAC_BITS-1+W:FRAC_BITS-1];
      end
      if (cmd.add) begin
         esc_ff    <= it_ff - CNT_W'(status.sq_fail);
         inside_ff <= status.at_limit & ~status.sq_fail;
         if (!stop) begin
            zx_ff <= nx[W-1:0];
            zy_ff <= ny[W-1:0];
            it_ff <= it_ff + CNT_W'(1);
         end
      end
   end

   // Gray level: binary search for the largest g with g*g*(limit-1) <= 65025*count.
   logic [GRAY_W-1:0]    g_ff, trial;
   logic [GRAY_SQ_W-1:0] gsq_ff;
   logic [LIM_W-1:0]     lim_ff, gprod;

   assign trial = g_ff | (GRAY_W'(1) << cmd.gray_bit);
   assign gprod = LIM_W'(gsq_ff) * LIM_W'(DEN);

   always_ff @(posedge clock) begin
      if (cmd.gray_init) begin
         g_ff   <= '0;
         lim_ff <= LIM_W'(esc_ff) * LIM_W'(GRAY_SCALE);
      end
      if (cmd.gray_sq) begin
         gsq_ff <= GRAY_SQ_W'(trial) * GRAY_SQ_W'(trial);
      end
      if (cmd.gray_cmp && gprod <= lim_ff) begin
         g_ff <= trial;
      end
   end

   logic [CNT_W+COUNT_W-1:0] esc_ext;
   logic [GRAY_W-1:0]        gray_ff;
   logic                     rsp_inside_ff;
   logic [COUNT_W-1:0]       count_ff;

   assign esc_ext = {COUNT_W'(0), esc_ff};

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         gray_ff       <= inside_ff ? '0 : g_ff;
         rsp_inside_ff <= inside_ff;
         count_ff      <= esc_ext[COUNT_W-1:0];
      end
   end

   assign gray         = gray_ff;
   assign inside_res   = rsp_inside_ff;
   assign escape_count = count_ff;

endmodule
`default_nettype wire

[sv/mep_controller.sv]
`default_nettype none
module mep_controller #(
   parameter int FRAC_BITS = 28
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   input  wire mep_pkg::mep_status_type status,
   output mep_pkg::mep_cmd_type         cmd
);
   import mep_pkg::*;

   localparam int QW     = PIXEL_W + 1 + FRAC_BITS;
   localparam int STEP_W = $clog2(QW);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DIV   = 4'd1;
   localparam logic [3:0] S_MAP   = 4'd2;
   localparam logic [3:0] S_MUL   = 4'd3;
   localparam logic [3:0] S_ADD   = 4'd4;
   localparam logic [3:0] S_GINIT = 4'd5;
   localparam logic [3:0] S_GSQ   = 4'd6;
   localparam logic [3:0] S_GCMP  = 4'd7;
   localparam logic [3:0] S_OUT   = 4'd8;

   logic [3:0]            state_ff, state_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [GRAY_BIT_W-1:0] bit_ff, bit_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      step_in  = step_ff;
      bit_in   = bit_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.div_start = 1'b1;
               step_in       = STEP_W'(QW - 1);
               state_in      = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (step_ff == '0) begin
               state_in = S_MAP;
            end else begin
               step_in = step_ff - STEP_W'(1);
            end
         end
         S_MAP: begin
            cmd.map  = 1'b1;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_ADD;
         end
         S_ADD: begin
            cmd.add = 1'b1;
            if (status.sq_fail || status.bound_fail || status.at_limit) begin
               state_in = S_GINIT;
            end else begin
               state_in = S_MUL;
            end
         end
         S_GINIT: begin
            cmd.gray_init = 1'b1;
            bit_in        = GRAY_BIT_W'(GRAY_W - 1);
            state_in      = S_GSQ;
         end
         S_GSQ: begin
            cmd.gray_sq  = 1'b1;
            cmd.gray_bit = bit_ff;
            state_in     = S_GCMP;
         end
         S_GCMP: begin
            cmd.gray_cmp = 1'b1;
            cmd.gray_bit = bit_ff;
            if (bit_ff == '0) begin
               state_in = S_OUT;
            end else begin
               bit_in   = bit_ff - GRAY_BIT_W'(1);
               state_in = S_GSQ;
            end
         end
         S_OUT: begin
            // The result register is free when empty or emptied by this transfer.
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rsp_valid_in = cmd.out_load | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         bit_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         bit_ff       <= bit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

[bench/testbench.sv]
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import mep_pkg::*;

   localparam int MAX_ITER     = 512;
   localparam int FRAC_BITS    = 28;
   localparam int HOLD_CYCLES  = 3000;
   localparam int QUIET_LIMIT  = 20000;
   localparam int END_SLACK    = 1200;
   localparam int PHASES       = 16;
   localparam int PHASE_PIXELS = 72;

   localparam longint ESCAPE_BOUND  = longint'(2) << FRAC_BITS;
   localparam longint RADIUS_SQ     = longint'(4) << FRAC_BITS;
   localparam longint X_OFFSET      = longint'(3) << (FRAC_BITS - 1);
   localparam longint Y_OFFSET      = longint'(1) << FRAC_BITS;
   localparam longint FULL_SCALE_SQ = 255 * 255;

   typedef struct {
      logic [PIXEL_W-1:0] x;
      logic [PIXEL_W-1:0] y;
      logic [GRAY_W-1:0]  gray;
      logic               in_set;
      logic [COUNT_W-1:0] steps;
   } pixel_outcome_type;

   logic                   clock            = 1'b0;
   logic                   reset            = 1'b1;
   logic                   req_valid        = 1'b0;
   logic                   req_stall;
   logic [PIXEL_W-1:0]     req_pixel_x      = '0;
   logic [PIXEL_W-1:0]     req_pixel_y      = '0;
   logic                   rsp_valid;
   logic                   rsp_stall        = 1'b0;
   logic [GRAY_W-1:0]      rsp_gray;
   logic                   rsp_inside_res;
   logic [COUNT_W-1:0]     rsp_escape_count;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index        = CSR_IMAGE_WIDTH;
   logic [DIM_W-1:0]       csr_wdata        = '0;

   // Image size as the block should currently see it.
   logic [DIM_W-1:0] plane_width  = DIM_RESET;
   logic [DIM_W-1:0] plane_height = DIM_RESET;

   pixel_outcome_type pending_pixels[$];

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   logic hold_start       = 1'b0;
   int hold_count         = 0;
   int quiet_cycles       = 0;
   int mismatch_count     = 0;
   int pixels_sent        = 0;
   int pixels_checked     = 0;
   int inside_seen        = 0;
   int longest_escape     = 0;
   int size_settings      = 0;

   mandelbrot_escape_pixel_core #(
      .MAX_ITER  (MAX_ITER),
      .FRAC_BITS (FRAC_BITS)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pixel_x      (req_pixel_x),
      .req_pixel_y      (req_pixel_y),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_gray         (rsp_gray),
      .rsp_inside_res   (rsp_inside_res),
      .rsp_escape_count (rsp_escape_count),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Exact product of two fixed-point values, floored after dropping shift bits.
   function automatic longint floored_product(input longint a, input longint b,
                                              input int shift);
      logic signed [127:0] full;
      full = a;
      full = full * b;
      full = full >>> shift;
      return full[63:0];
   endfunction

   function automatic longint plane_coord(input logic [PIXEL_W-1:0] p,
                                          input logic [DIM_W-1:0] size,
                                          input longint offset);
      longint unsigned span;
      longint unsigned scaled;
      longint top;
      longint v;
      top = (longint'(8) << FRAC_BITS) - 1;
      span = (size == 0) ? 64'd1 : 64'(size);
      scaled = longint'(p) << (FRAC_BITS + 1);
      scaled = scaled / span;
      if (scaled >= (64'd16 << FRAC_BITS)) return top;
      v = longint'(scaled) - offset;
      if (v > top) v = top;
      if (v < -top - 1) v = -top - 1;
      return v;
   endfunction

   function automatic pixel_outcome_type escape_time_of(input logic [PIXEL_W-1:0] x,
                                                        input logic [PIXEL_W-1:0] y);
      pixel_outcome_type outcome;
      longint cx;
      longint cy;
      longint zx;
      longint zy;
      longint nx;
      longint ny;
      longint level;
      int steps;
      bit escaped;
      cx = plane_coord(x, plane_width, X_OFFSET);
      cy = plane_coord(y, plane_height, Y_OFFSET);
      zx = 0;
      zy = 0;
      steps = 0;
      escaped = 1'b0;
      while (!escaped && steps < MAX_ITER) begin
         nx = floored_product(zx, zx, FRAC_BITS) - floored_product(zy, zy, FRAC_BITS) + cx;
         ny = floored_product(zx, zy, FRAC_BITS - 1) + cy;
         if (nx > ESCAPE_BOUND || nx < -ESCAPE_BOUND ||
             ny > ESCAPE_BOUND || ny < -ESCAPE_BOUND) begin
            escaped = 1'b1;
         end else if (floored_product(nx, nx, FRAC_BITS) +
                      floored_product(ny, ny, FRAC_BITS) > RADIUS_SQ) begin
            escaped = 1'b1;
         end else begin
            zx = nx;
            zy = ny;
            steps++;
         end
      end
      outcome.x = x;
      outcome.y = y;
      if (escaped) begin
         // Largest g with g*g*(limit-1) <= 255*255*steps.
         level = 0;
         while (level < 255 &&
                (level + 1) * (level + 1) * (MAX_ITER - 1) <= FULL_SCALE_SQ * steps)
            level++;
         outcome.gray   = GRAY_W'(level);
         outcome.in_set = 1'b0;
         outcome.steps  = COUNT_W'(steps);
      end else begin
         outcome.gray   = '0;
         outcome.in_set = 1'b1;
         outcome.steps  = COUNT_W'(MAX_ITER);
      end
      return outcome;
   endfunction

   task automatic report_error(input string what, input int got, input int want);
      $display("ERROR at %0t ns: %s: got %0d, expected %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : check_results
      pixel_outcome_type want;
      string where;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pixels.size() == 0) begin
            report_error("result transfer with no pixel pending, gray", int'(rsp_gray), -1);
         end else begin
            want = pending_pixels.pop_front();
            where = $sformatf("pixel (%0d,%0d)", want.x, want.y);
            if (rsp_gray !== want.gray)
               report_error({where, " gray"}, int'(rsp_gray), int'(want.gray));
            if (rsp_inside_res !== want.in_set)
               report_error({where, " inside flag"}, int'(rsp_inside_res),
                            int'(want.in_set));
            if (rsp_escape_count !== want.steps)
               report_error({where, " escape count"}, int'(rsp_escape_count),
                            int'(want.steps));
            pixels_checked++;
            if (want.in_set) inside_seen++;
            else if (int'(want.steps) > longest_escape) longest_escape = int'(want.steps);
         end
      end
   end

   // Output side: random stalls, or a long hold-off once requested.
   always @(posedge clock) begin
      if (hold_count != 0) begin
         rsp_stall  <= 1'b1;
         hold_count <= hold_count - 1;
      end else if (hold_start) begin
         rsp_stall  <= 1'b1;
         hold_count <= HOLD_CYCLES;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Timeout: no transfer for %0d cycles, %0d pixels pending",
                  quiet_cycles, pending_pixels.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_pixel(input logic [PIXEL_W-1:0] x, input logic [PIXEL_W-1:0] y);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_pixel_x <= x;
      req_pixel_y <= y;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_pixels.push_back(escape_time_of(x, y));
      pixels_sent++;
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_pixels.size() != 0) @(posedge clock);
   endtask

   // Only called with the block idle; never twice without a transfer in between.
   task automatic set_image_size(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_IMAGE_WIDTH;
      csr_wdata        <= w;
      @(posedge clock);
      csr_index        <= CSR_IMAGE_HEIGHT;
      csr_wdata        <= h;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      plane_width  = w;
      plane_height = h;
      size_settings++;
   endtask

   task automatic set_traffic(input int idle_pct, input int stall_pct);
      sender_idle_pct = idle_pct;
      receiver_stall_pct <= stall_pct;
   endtask

   function automatic logic [PIXEL_W-1:0] random_coord(input logic [DIM_W-1:0] size);
      int unsigned span;
      span = (size == 0) ? 32'd1 : 32'(size);
      if (span > (1 << PIXEL_W)) span = 1 << PIXEL_W;
      // A tenth of the coordinates lie anywhere in the pixel range, often beyond the image.
      if ($urandom_range(0, 9) == 0) return PIXEL_W'($urandom);
      return PIXEL_W'($urandom_range(0, span - 1));
   endfunction

   // Reset size: corners, the origin, and points inside the set on and off the real axis.
   task automatic test_reset_size();
      set_traffic(0, 0);
      send_pixel(0, 0);
      send_pixel(8191, 8191);
      send_pixel(6144, 4096);
      send_pixel(2048, 4096);
      send_pixel(0, 4096);
      send_pixel(4096, 6144);
      send_pixel(8191, 0);
      send_pixel(0, 8191);
      wait_for_results();
   endtask

   // Zero size taken as one, coordinates beyond the size, and saturated points.
   task automatic test_size_extremes();
      set_image_size(0, 0);
      send_pixel(0, 0);
      send_pixel(1, 1);
      send_pixel(8191, 8191);
      wait_for_results();
      set_image_size(1, 1);
      send_pixel(0, 0);
      send_pixel(1, 0);
      wait_for_results();
      set_image_size(1000, 1000);
      send_pixel(5000, 5000);
      send_pixel(7999, 4000);
      wait_for_results();
      set_image_size(16383, 16383);
      send_pixel(0, 0);
      send_pixel(8191, 8191);
      send_pixel(5461, 8191);
      wait_for_results();
   endtask

   // Hold the output long enough that the block fills and stalls its input.
   task automatic test_output_hold();
      set_image_size(DIM_RESET, DIM_RESET);
      set_traffic(0, 0);
      hold_start <= 1'b1;
      @(posedge clock);
      hold_start <= 1'b0;
      for (int n = 0; n < 8; n++)
         send_pixel(random_coord(plane_width), random_coord(plane_height));
      wait_for_results();
   endtask

   task automatic test_random_images();
      int widths[8]  = '{8192, 640, 16383, 0, 1, 96, 8192, 3000};
      int heights[8] = '{8192, 480, 16383, 0, 1, 64, 4096, 9000};
      int w;
      int h;
      for (int phase = 0; phase < PHASES; phase++) begin
         w = widths[phase % 8];
         h = heights[phase % 8];
         if (phase % 8 == 3) begin
            w = $urandom_range(0, 16383);
            h = $urandom_range(0, 16383);
         end
         set_image_size(DIM_W'(w), DIM_W'(h));
         case (phase % 4)
            0: set_traffic(0, 0);
            1: set_traffic(49, 0);
            2: set_traffic(0, 49);
            default: set_traffic(12, 12);
         endcase
         for (int n = 0; n < PHASE_PIXELS; n++) begin
            // Now and then the sender stops until the block has drained.
            if (n == PHASE_PIXELS / 2 && phase % 5 == 0) wait_for_results();
            send_pixel(random_coord(plane_width), random_coord(plane_height));
         end
         wait_for_results();
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_reset_size();
      test_size_extremes();
      test_output_hold();
      test_random_images();
      wait_for_results();
      repeat (END_SLACK) @(posedge clock);
      $display("Covered %0d pixels over %0d image size settings and four traffic patterns;",
               pixels_checked, size_settings);
      $display("%0d were inside the set and the longest escape took %0d steps.",
               inside_seen, longest_escape);
      if (mismatch_count == 0 && pending_pixels.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
`default_nettype wire

[filelist.f]
sv/mep_pkg.sv
sv/mep_div_lane.sv
sv/mep_datapath.sv
sv/mep_controller.sv
sv/mandelbrot_escape_pixel_core.sv
bench/testbench.sv
